// ----- rtl/core/lc3se_pkg.sv -----
// shared types, opcodes and helpers for the lc3 subset execute core
// no dependencies
package lc3se_pkg;

    localparam logic [3:0] OPC_BR  = 4'd0;
    localparam logic [3:0] OPC_ADD = 4'd1;
    localparam logic [3:0] OPC_AND = 4'd5;
    localparam logic [3:0] OPC_JMP = 4'd12;

    localparam logic [2:0] FLAG_P = 3'b001;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_N = 3'b100;

    localparam logic [15:0] RESET_PC = 16'h3000;

    typedef struct packed {
        logic        en;
        logic [2:0]  addr;
        logic [15:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        wrote;
        logic [2:0]  dest_index;
        logic [15:0] dest_value;
        logic [2:0]  flags;
        logic        fault;
        logic        halt;
    } t_exec_out;

    function automatic logic [15:0] sext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] v);
        return {{7{v[8]}}, v};
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'd0) begin
            f = FLAG_Z;
        end else if (v[15]) begin
            f = FLAG_N;
        end else begin
            f = FLAG_P;
        end
        return f;
    endfunction

endpackage

// ----- rtl/core/lc3se_regfile.sv -----
// eight-entry register file, two registered read ports, one write port
// depends on lc3se_pkg; entries not yet written since reset read as zero
module lc3se_regfile (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [2:0]         i_rd_addr_a,
    input  logic [2:0]         i_rd_addr_b,
    output logic [15:0]        o_rd_data_a,
    output logic [15:0]        o_rd_data_b,
    input  lc3se_pkg::t_rf_wr  i_wr
);
    import lc3se_pkg::*;

    logic [15:0] r_mem [8];
    logic [7:0]  r_vld;
    logic [15:0] r_rd_a;
    logic [15:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a] : 16'd0;
            r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b] : 16'd0;
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- rtl/core/lc3se_exec.sv -----
// execute logic: alu, branch resolution, jump and fault detection
// depends on lc3se_pkg
module lc3se_exec (
    input  logic [15:0]           i_instr,
    input  logic [15:0]           i_op_a,
    input  logic [15:0]           i_op_b,
    input  logic [15:0]           i_pc,
    input  logic [2:0]            i_flags,
    input  logic                  i_halted,
    output lc3se_pkg::t_exec_out  o_res
);
    import lc3se_pkg::*;

    logic [3:0]  op;
    logic [2:0]  dr;
    logic [15:0] pc_inc;
    logic [15:0] b_val;
    logic [15:0] alu_val;

    assign op      = i_instr[15:12];
    assign dr      = i_instr[11:9];
    assign pc_inc  = i_pc + 16'd1;
    assign b_val   = i_instr[5] ? sext5(i_instr[4:0]) : i_op_b;
    assign alu_val = (op == OPC_ADD) ? (i_op_a + b_val) : (i_op_a & b_val);

    always_comb begin
        o_res            = '0;
        o_res.next_pc    = pc_inc;
        o_res.flags      = i_flags;
        if (i_halted) begin
            o_res.next_pc = i_pc;
            o_res.fault   = 1'b1;
        end else begin
            case (op)
                OPC_ADD, OPC_AND: begin
                    o_res.wrote      = 1'b1;
                    o_res.dest_index = dr;
                    o_res.dest_value = alu_val;
                    o_res.flags      = flags_of(alu_val);
                end
                OPC_BR: begin
                    if ((dr & i_flags) != 3'd0) begin
                        o_res.next_pc = pc_inc + sext9(i_instr[8:0]);
                    end
                end
                OPC_JMP: begin
                    o_res.next_pc = i_op_a;
                end
                default: begin
                    o_res.fault = 1'b1;
                    o_res.halt  = 1'b1;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/lc3_subset_execute_core.sv -----
// lc3 subset execute core: one instruction word in, one result word out
// the instruction word is registered into stage two, then the result word into the output register
// throughput: one word per cycle while the output is not stalled; operand read in the
// register file memory, then execute and write back with forwarding of the previous write
// reset: pc loads 0x3000, flags and halt clear, register file reads zero
module lc3_subset_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_instruction_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic        o_wrote_register,
    output logic [2:0]  o_dest_index,
    output logic [15:0] o_dest_value,
    output logic [2:0]  o_cond_flags,
    output logic        o_fault
);
    import lc3se_pkg::*;

    logic        r_s2_valid;
    logic [15:0] r_s2_instr;
    logic [15:0] r_pc;
    logic [2:0]  r_flags;
    logic        r_halted;
    logic        r_fwd_vld;
    logic [2:0]  r_fwd_idx;
    logic [15:0] r_fwd_data;
    logic        r_out_valid;
    t_exec_out   r_out;

    logic        in_accept;
    logic        s2_fire;
    logic [15:0] rd_a;
    logic [15:0] rd_b;
    logic [15:0] op_a;
    logic [15:0] op_b;
    t_exec_out   res;
    t_rf_wr      rf_wr;

    assign s2_fire    = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s2_valid && !s2_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign rf_wr.en   = s2_fire && res.wrote;
    assign rf_wr.addr = res.dest_index;
    assign rf_wr.data = res.dest_value;

    lc3se_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (i_instruction_word[8:6]),
        .i_rd_addr_b (i_instruction_word[2:0]),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b),
        .i_wr        (rf_wr)
    );

    // write from the previous cycle is not yet in the read data
    assign op_a = (r_fwd_vld && r_fwd_idx == r_s2_instr[8:6]) ? r_fwd_data : rd_a;
    assign op_b = (r_fwd_vld && r_fwd_idx == r_s2_instr[2:0]) ? r_fwd_data : rd_b;

    lc3se_exec u_exec (
        .i_instr  (r_s2_instr),
        .i_op_a   (op_a),
        .i_op_b   (op_b),
        .i_pc     (r_pc),
        .i_flags  (r_flags),
        .i_halted (r_halted),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_pc        <= RESET_PC;
            r_flags     <= '0;
            r_halted    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_pc        <= res.next_pc;
                r_flags     <= res.flags;
                r_halted    <= r_halted || res.halt;
                r_fwd_vld   <= res.wrote;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cfg_valid) begin
                    r_pc <= i_cfg_data;
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2_instr <= i_instruction_word;
        end
        if (s2_fire) begin
            r_out      <= res;
            r_fwd_idx  <= res.dest_index;
            r_fwd_data <= res.dest_value;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_next_pc        = r_out.next_pc;
    assign o_wrote_register = r_out.wrote;
    assign o_dest_index     = r_out.dest_index;
    assign o_dest_value     = r_out.dest_value;
    assign o_cond_flags     = r_out.flags;
    assign o_fault          = r_out.fault;

endmodule

// ----- rtl/core/lc3se_checker.sv -----
// port-level checks for the lc3 subset execute core
// depends on lc3_subset_execute_core; bound to it below
module lc3se_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_next_pc,
    input logic        o_wrote_register,
    input logic [2:0]  o_dest_index,
    input logic [15:0] o_dest_value,
    input logic [2:0]  o_cond_flags,
    input logic        o_fault
);
    logic r_seen_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_fault <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_fault) begin
            r_seen_fault <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_next_pc)
            && $stable(o_dest_value) && $stable(o_fault))
        else $error("stalled result word changed");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_fault |-> o_fault)
        else $error("fault not held after halt");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_wrote_register |-> o_dest_index == 3'd0 && o_dest_value == 16'd0)
        else $error("destination fields set without a write");

    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault |-> !o_wrote_register)
        else $error("register written on fault");

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_cond_flags))
        else $error("more than one condition flag set");

endmodule

bind lc3_subset_execute_core lc3se_checker u_lc3se_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_next_pc        (o_next_pc),
    .o_wrote_register (o_wrote_register),
    .o_dest_index     (o_dest_index),
    .o_dest_value     (o_dest_value),
    .o_cond_flags     (o_cond_flags),
    .o_fault          (o_fault)
);
